// ===== design/vppq_pkg.sv =====
package vppq_pkg;

	// verdict codes
	localparam logic [1:0] VERDICT_OK       = 2'd0;
	localparam logic [1:0] VERDICT_INTERVAL = 2'd1;
	localparam logic [1:0] VERDICT_VOICED   = 2'd2;
	localparam logic [1:0] VERDICT_HEIGHT   = 2'd3;
	localparam int unsigned VERDICT_BITS = 2;

	// register indexes
	localparam int unsigned CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_INTERVAL = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_RANGE    = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_RANGE    = 2'd3;

	// reset values of the registers
	localparam int unsigned RST_MIN_INTERVAL = 15;
	localparam int unsigned RST_MAX_INTERVAL = 62;
	localparam int unsigned RST_MIN_RANGE    = 10;
	localparam int unsigned RST_MAX_RANGE    = 500;

	// voiced requirement is (min_interval / 5) * 4
	localparam int unsigned DIV5_RECIP = 52429;
	localparam int unsigned DIV5_SHIFT = 18;

	// exact divide by five for 16-bit values, by reciprocal multiply
	function automatic logic [15:0] div5(input logic [15:0] x);
		logic [31:0] prod;
		begin
			prod = 32'(x) * 32'(DIV5_RECIP);
			div5 = 16'(prod >> DIV5_SHIFT);
		end
	endfunction

endpackage

// ===== design/vppq_cfg.sv =====
module vppq_cfg #(
	parameter int unsigned PITCH_BITS    = 14,
	parameter int unsigned INTERVAL_BITS = 8,
	parameter int unsigned CFG_BITS      = 14
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [vppq_pkg::CFG_IDX_BITS-1:0] cfg_idx,
	input  logic [CFG_BITS-1:0]               cfg_data,
	output logic [INTERVAL_BITS-1:0]          min_interval,
	output logic [INTERVAL_BITS-1:0]          max_interval,
	output logic [INTERVAL_BITS-1:0]          need_voiced,
	output logic [PITCH_BITS-1:0]             min_range,
	output logic [PITCH_BITS-1:0]             max_range
);
	import vppq_pkg::*;

	logic [INTERVAL_BITS-1:0] min_interval_q;
	logic [INTERVAL_BITS-1:0] max_interval_q;
	logic [INTERVAL_BITS-1:0] need_q;
	logic [PITCH_BITS-1:0]    min_range_q;
	logic [PITCH_BITS-1:0]    max_range_q;
	logic [INTERVAL_BITS-1:0] wr_interval;
	logic [15:0]              wr_quot;
	logic [15:0]              rst_quot;

	assign wr_interval = cfg_data[INTERVAL_BITS-1:0];
	assign wr_quot     = div5(16'(wr_interval));
	assign rst_quot    = div5(16'(INTERVAL_BITS'(RST_MIN_INTERVAL)));

	// register file, voiced requirement kept alongside the minimum interval
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_interval_q <= INTERVAL_BITS'(RST_MIN_INTERVAL);
			max_interval_q <= INTERVAL_BITS'(RST_MAX_INTERVAL);
			need_q         <= INTERVAL_BITS'({rst_quot, 2'b00});
			min_range_q    <= PITCH_BITS'(RST_MIN_RANGE);
			max_range_q    <= PITCH_BITS'(RST_MAX_RANGE);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MIN_INTERVAL: begin
					min_interval_q <= wr_interval;
					need_q         <= INTERVAL_BITS'({wr_quot, 2'b00});
				end
				REG_MAX_INTERVAL: max_interval_q <= wr_interval;
				REG_MIN_RANGE:    min_range_q    <= cfg_data[PITCH_BITS-1:0];
				REG_MAX_RANGE:    max_range_q    <= cfg_data[PITCH_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign min_interval = min_interval_q;
	assign max_interval = max_interval_q;
	assign need_voiced  = need_q;
	assign min_range    = min_range_q;
	assign max_range    = max_range_q;

endmodule

// ===== design/vppq_track.sv =====
module vppq_track #(
	parameter int unsigned PITCH_BITS    = 14,
	parameter int unsigned INTERVAL_BITS = 8,
	parameter int unsigned FRAME_BITS    = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  logic [PITCH_BITS-1:0]             pitch,
	input  logic [INTERVAL_BITS-1:0]          min_interval,
	input  logic [INTERVAL_BITS-1:0]          max_interval,
	input  logic [INTERVAL_BITS-1:0]          need_voiced,
	input  logic [PITCH_BITS-1:0]             min_range,
	input  logic [PITCH_BITS-1:0]             max_range,
	output logic                              res_valid,
	output logic [vppq_pkg::VERDICT_BITS-1:0] verdict,
	output logic [FRAME_BITS-1:0]             first_peak_frame,
	output logic [INTERVAL_BITS-1:0]          interval_steps,
	output logic [INTERVAL_BITS-1:0]          voiced_between,
	output logic [PITCH_BITS-1:0]             height_cents
);
	import vppq_pkg::*;

	localparam logic [INTERVAL_BITS-1:0] SAT_MAX = '1;

	logic [PITCH_BITS-1:0]    last_q;
	logic [PITCH_BITS-1:0]    second_q;
	logic [FRAME_BITS-1:0]    frame_q;
	logic                     have_q;
	logic [FRAME_BITS-1:0]    peak_frame_q;
	logic [PITCH_BITS-1:0]    peak_pitch_q;
	logic [INTERVAL_BITS-1:0] voiced_q;
	logic [PITCH_BITS-1:0]    runmin_q;
	logic [INTERVAL_BITS-1:0] gap_q;

	logic [INTERVAL_BITS-1:0] gap_inc;
	logic                     is_peak;
	logic [PITCH_BITS-1:0]    top;
	logic [PITCH_BITS-1:0]    height;

	// gap seen by this frame, saturating
	always_comb begin
		gap_inc = gap_q;
		if (have_q && gap_q != SAT_MAX)
			gap_inc = gap_q + 1'b1;
	end

	// the previous sample is a peak once its successor is here
	assign is_peak = (last_q != '0) && (second_q != '0) && (pitch != '0) &&
		(last_q >= second_q) && (last_q > pitch);

	assign top    = (peak_pitch_q > last_q) ? peak_pitch_q : last_q;
	assign height = top - runmin_q;

	// judge the pair, first failing check wins
	always_comb begin
		if (gap_inc < min_interval || gap_inc > max_interval)
			verdict = VERDICT_INTERVAL;
		else if (voiced_q < need_voiced)
			verdict = VERDICT_VOICED;
		else if (height < min_range || height > max_range)
			verdict = VERDICT_HEIGHT;
		else
			verdict = VERDICT_OK;
	end

	assign res_valid        = step && is_peak && have_q;
	assign first_peak_frame = peak_frame_q;
	assign interval_steps   = gap_inc;
	assign voiced_between   = voiced_q;
	assign height_cents     = height;

	// tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q       <= '0;
			second_q     <= '0;
			frame_q      <= '0;
			have_q       <= 1'b0;
			peak_frame_q <= '0;
			peak_pitch_q <= '0;
			voiced_q     <= '0;
			runmin_q     <= '0;
			gap_q        <= '0;
		end else if (step) begin
			second_q <= last_q;
			last_q   <= pitch;
			frame_q  <= frame_q + 1'b1;
			if (is_peak) begin
				have_q       <= 1'b1;
				peak_frame_q <= frame_q - 1'b1;
				peak_pitch_q <= last_q;
				voiced_q     <= '0;
				runmin_q     <= last_q;
				gap_q        <= '0;
			end else begin
				gap_q <= gap_inc;
				if (have_q && last_q != '0) begin
					if (voiced_q != SAT_MAX)
						voiced_q <= voiced_q + 1'b1;
					if (last_q < runmin_q)
						runmin_q <= last_q;
				end
			end
		end
	end

endmodule

// ===== design/vibrato_peak_pair_qualifier_core.sv =====
// an accepted word passes the input register, and its result, if any, the result register on m_tdata
// throughput: one word per cycle, limited only by output back-pressure
// a result waits in the output register while the next word is taken in
// arst_n clears all tracking state and loads the register reset values
// frame numbering restarts at zero after reset
module vibrato_peak_pair_qualifier_core #(
	parameter int unsigned PITCH_BITS    = 14,
	parameter int unsigned INTERVAL_BITS = 8,
	parameter int unsigned FRAME_BITS    = 24,
	parameter int unsigned CFG_BITS =
		(PITCH_BITS > INTERVAL_BITS) ? PITCH_BITS : INTERVAL_BITS,
	parameter int unsigned IN_W  = ((PITCH_BITS + 7) / 8) * 8,
	parameter int unsigned OUT_W =
		((2 + FRAME_BITS + 2 * INTERVAL_BITS + PITCH_BITS + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [vppq_pkg::CFG_IDX_BITS-1:0] cfg_idx,
	input  logic [CFG_BITS-1:0]               cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// pitch_cents
	input  logic [IN_W-1:0]                   s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// verdict, first_peak_frame, interval_steps, voiced_between, height_cents
	output logic [OUT_W-1:0]                  m_tdata
);
	import vppq_pkg::*;

	localparam int unsigned RES_W = VERDICT_BITS + FRAME_BITS + 2 * INTERVAL_BITS + PITCH_BITS;

	logic [PITCH_BITS-1:0]    pitch_s1;
	logic                     valid_s1;
	logic                     advance;
	logic                     step;
	logic [INTERVAL_BITS-1:0] min_interval;
	logic [INTERVAL_BITS-1:0] max_interval;
	logic [INTERVAL_BITS-1:0] need_voiced;
	logic [PITCH_BITS-1:0]    min_range;
	logic [PITCH_BITS-1:0]    max_range;
	logic                     res_valid;
	logic [VERDICT_BITS-1:0]  verdict;
	logic [FRAME_BITS-1:0]    first_peak_frame;
	logic [INTERVAL_BITS-1:0] interval_steps;
	logic [INTERVAL_BITS-1:0] voiced_between;
	logic [PITCH_BITS-1:0]    height_cents;
	logic                     out_valid_q;
	logic [RES_W-1:0]         out_data_q;

	// handshake
	assign advance  = !out_valid_q || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			pitch_s1 <= s_tdata[PITCH_BITS-1:0];
	end

	vppq_cfg #(
		.PITCH_BITS   (PITCH_BITS),
		.INTERVAL_BITS(INTERVAL_BITS),
		.CFG_BITS     (CFG_BITS)
	) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.min_interval(min_interval),
		.max_interval(max_interval),
		.need_voiced (need_voiced),
		.min_range   (min_range),
		.max_range   (max_range)
	);

	vppq_track #(
		.PITCH_BITS   (PITCH_BITS),
		.INTERVAL_BITS(INTERVAL_BITS),
		.FRAME_BITS   (FRAME_BITS)
	) u_track (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (step),
		.pitch           (pitch_s1),
		.min_interval    (min_interval),
		.max_interval    (max_interval),
		.need_voiced     (need_voiced),
		.min_range       (min_range),
		.max_range       (max_range),
		.res_valid       (res_valid),
		.verdict         (verdict),
		.first_peak_frame(first_peak_frame),
		.interval_steps  (interval_steps),
		.voiced_between  (voiced_between),
		.height_cents    (height_cents)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid)
			out_data_q <= {height_cents, voiced_between, interval_steps,
				first_peak_frame, verdict};
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'(out_data_q);

endmodule

// ===== bench/vibrato_peak_pair_qualifier_core_test.sv =====
module vibrato_peak_pair_qualifier_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import vppq_pkg::*;

	localparam int PITCH_W    = 14;
	localparam int STEP_W     = 8;
	localparam int FRAME_W    = 24;
	localparam int CFG_W      = 14;
	localparam int HOLD_LEN   = 250;
	localparam int SETTLE_LEN = 4;

	// one judged peak pair, packed as on m_tdata (verdict in the lowest bits)
	typedef struct packed {
		logic [PITCH_W-1:0]      height_cents;
		logic [STEP_W-1:0]       voiced_between;
		logic [STEP_W-1:0]       interval_steps;
		logic [FRAME_W-1:0]      first_peak_frame;
		logic [VERDICT_BITS-1:0] verdict;
	} pair_verdict_t;

	typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_RESULT} row_kind_t;

	typedef struct packed {
		logic [PITCH_W-1:0] pitch;
		row_kind_t          kind;
		pair_verdict_t      want;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_idx;
	logic [CFG_W-1:0]   cfg_data;
	logic               s_tvalid;
	logic               s_tready;
	// pitch_cents
	logic [15:0]        s_tdata;
	logic               m_tvalid;
	logic               m_tready;
	// verdict, first_peak_frame, interval_steps, voiced_between, height_cents
	logic [55:0]        m_tdata;

	vibrato_peak_pair_qualifier_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// 8 ns clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	initial begin
		#5ms;
		$display("FAILED: results differ");
		$finish;
	end

	// register copies
	logic [STEP_W-1:0]  lim_min_interval;
	logic [STEP_W-1:0]  lim_max_interval;
	logic [PITCH_W-1:0] lim_min_range;
	logic [PITCH_W-1:0] lim_max_range;

	// peak tracking state
	logic [PITCH_W-1:0] prev_pitch;
	logic [PITCH_W-1:0] prev2_pitch;
	logic [FRAME_W-1:0] next_frame;
	bit                 seen_peak;
	logic [FRAME_W-1:0] anchor_frame;
	logic [PITCH_W-1:0] anchor_pitch;
	logic [STEP_W-1:0]  voiced_run;
	logic [PITCH_W-1:0] trough_pitch;
	logic [STEP_W-1:0]  steps_since_peak;

	pair_verdict_t pending_verdicts[$];
	int            mismatch_count;

	// idling controls
	int sender_idle_pct;
	int recv_stall_pct;
	logic hold_active;
	event hold_go;

	// pitch contour generator
	int ramp_from, ramp_to, ramp_len, ramp_pos, ramp_base;
	bit ramp_up;
	int drop_left;
	int long_pct;

	function automatic logic [STEP_W-1:0] sat_step(input logic [STEP_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// append one expected verdict at the tail of the queue
	task automatic enqueue_verdict(input pair_verdict_t v);
		pending_verdicts = {pending_verdicts, v};
	endtask

	// advance the tracker by one frame, report a verdict when a peak pair closes
	task automatic judge_frame(input logic [PITCH_W-1:0] x, output bit found,
			output pair_verdict_t res);
		logic [PITCH_W-1:0] cand;
		logic [FRAME_W-1:0] cand_frame;
		logic [STEP_W-1:0]  need;
		logic [PITCH_W-1:0] top;
		logic [PITCH_W-1:0] height;
		bit                 peak;
		cand = prev_pitch;
		cand_frame = next_frame - 1'b1;
		found = 1'b0;
		res = '0;
		if (seen_peak)
			steps_since_peak = sat_step(steps_since_peak);
		peak = cand != 0 && prev2_pitch != 0 && x != 0 && cand >= prev2_pitch && cand > x;
		if (peak) begin
			if (seen_peak) begin
				need = (lim_min_interval / 5) * 4;
				top = (anchor_pitch > cand) ? anchor_pitch : cand;
				height = top - trough_pitch;
				if (steps_since_peak < lim_min_interval || steps_since_peak > lim_max_interval)
					res.verdict = VERDICT_INTERVAL;
				else if (voiced_run < need)
					res.verdict = VERDICT_VOICED;
				else if (height < lim_min_range || height > lim_max_range)
					res.verdict = VERDICT_HEIGHT;
				else
					res.verdict = VERDICT_OK;
				res.first_peak_frame = anchor_frame;
				res.interval_steps = steps_since_peak;
				res.voiced_between = voiced_run;
				res.height_cents = height;
				found = 1'b1;
			end
			seen_peak = 1'b1;
			anchor_frame = cand_frame;
			anchor_pitch = cand;
			voiced_run = '0;
			trough_pitch = cand;
			steps_since_peak = '0;
		end else if (seen_peak && cand != 0) begin
			voiced_run = sat_step(voiced_run);
			if (cand < trough_pitch)
				trough_pitch = cand;
		end
		prev2_pitch = prev_pitch;
		prev_pitch = x;
		next_frame = next_frame + 1'b1;
	endtask

	// next pitch: ramps up and down around a drifting center, with dropouts and noise
	function automatic logic [PITCH_W-1:0] next_shaped_pitch();
		int r;
		int amp;
		int v;
		r = $urandom_range(99);
		if (drop_left > 0) begin
			drop_left--;
			return '0;
		end
		if (r < 3)
			return PITCH_W'($urandom);
		if (r < 5)
			return '0;
		if (ramp_pos >= ramp_len) begin
			ramp_from = ramp_to;
			ramp_up = !ramp_up;
			ramp_pos = 0;
			if ($urandom_range(9) == 0)
				ramp_base = $urandom_range(200, 16200);
			amp = ($urandom_range(9) == 0) ? $urandom_range(1, 8000) : $urandom_range(1, 400);
			ramp_len = ($urandom_range(99) < long_pct) ? $urandom_range(130, 300) :
				$urandom_range(1, 20);
			ramp_to = ramp_up ? ramp_base + amp : ramp_base - amp;
			if (ramp_to < 1)
				ramp_to = 1;
			if (ramp_to > 16383)
				ramp_to = 16383;
			if ($urandom_range(19) == 0)
				drop_left = $urandom_range(1, 6);
		end
		ramp_pos++;
		v = ramp_from + (ramp_to - ramp_from) * ramp_pos / ramp_len;
		return PITCH_W'(v);
	endfunction

	// offer one word, wait for it to be taken, then queue what it should produce
	task automatic feed_pitch(input logic [PITCH_W-1:0] pitch, input row_kind_t kind,
			input pair_verdict_t typed);
		bit            found;
		pair_verdict_t res;
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, pitch};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		judge_frame(pitch, found, res);
		case (kind)
			ROW_RESULT: enqueue_verdict(typed);
			ROW_NONE: ;
			default: if (found) enqueue_verdict(res);
		endcase
	endtask

	task automatic hold_input();
		s_tvalid <= 1'b0;
	endtask

	// stop sending and let every outstanding verdict come out
	task automatic settle();
		hold_input();
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_LEN) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_MIN_INTERVAL: lim_min_interval = data[STEP_W-1:0];
			REG_MAX_INTERVAL: lim_max_interval = data[STEP_W-1:0];
			REG_MIN_RANGE:    lim_min_range = data[PITCH_W-1:0];
			default:          lim_max_range = data[PITCH_W-1:0];
		endcase
	endtask

	// interval registers get random junk above their 8 bits
	task automatic write_settings(input int min_i, input int max_i, input int min_r,
			input int max_r);
		put_reg(REG_MIN_INTERVAL, {6'($urandom), 8'(min_i)});
		put_reg(REG_MAX_INTERVAL, {6'($urandom), 8'(max_i)});
		put_reg(REG_MIN_RANGE, CFG_W'(min_r));
		put_reg(REG_MAX_RANGE, CFG_W'(max_r));
		cfg_we <= 1'b0;
	endtask

	task automatic run_random(input int n, input int pause_at, input int hold_at);
		for (int i = 0; i < n; i++) begin
			if (i == hold_at)
				->hold_go;
			if (i == pause_at) begin
				hold_input();
				while (pending_verdicts.size() != 0)
					@(posedge clk);
			end
			feed_pitch(next_shaped_pitch(), ROW_PREDICT, '0);
		end
	endtask

	// long receiver hold-off, counted here
	initial begin
		hold_active = 1'b0;
		forever begin
			@(hold_go);
			hold_active <= 1'b1;
			repeat (HOLD_LEN) @(posedge clk);
			hold_active <= 1'b0;
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		if (hold_active)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// compare each delivered verdict word with the oldest prediction
	always @(posedge clk) begin
		pair_verdict_t got;
		pair_verdict_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = pair_verdict_t'(m_tdata);
			if (pending_verdicts.size() == 0) begin
				$error("verdict word with nothing pending: %h", m_tdata);
				mismatch_count++;
			end else begin
				want = pending_verdicts.pop_front();
				check_field("verdict", want.verdict, got.verdict);
				check_field("first_peak_frame", want.first_peak_frame, got.first_peak_frame);
				check_field("interval_steps", want.interval_steps, got.interval_steps);
				check_field("voiced_between", want.voiced_between, got.voiced_between);
				check_field("height_cents", want.height_cents, got.height_cents);
			end
		end
	end

	// directed rows: start of stream, a passing pair, short intervals at full scale
	stim_row_t directed_plan [0:24];

	initial begin
		directed_plan = '{
			'{14'd100,   ROW_NONE,    '0},
			'{14'd200,   ROW_NONE,    '0},
			'{14'd150,   ROW_NONE,    '0},
			'{14'd150,   ROW_PREDICT, '0},
			'{14'd150,   ROW_PREDICT, '0},
			'{14'd150,   ROW_PREDICT, '0},
			'{14'd150,   ROW_PREDICT, '0},
			'{14'd150,   ROW_PREDICT, '0},
			'{14'd150,   ROW_PREDICT, '0},
			'{14'd150,   ROW_PREDICT, '0},
			'{14'd150,   ROW_PREDICT, '0},
			'{14'd150,   ROW_PREDICT, '0},
			'{14'd150,   ROW_PREDICT, '0},
			'{14'd150,   ROW_PREDICT, '0},
			'{14'd150,   ROW_PREDICT, '0},
			'{14'd150,   ROW_PREDICT, '0},
			'{14'd300,   ROW_PREDICT, '0},
			'{14'd100,   ROW_RESULT,  '{14'd150, 8'd14, 8'd15, 24'd1, VERDICT_OK}},
			'{14'd16383, ROW_PREDICT, '0},
			'{14'd50,    ROW_RESULT,  '{14'd16283, 8'd1, 8'd2, 24'd16, VERDICT_INTERVAL}},
			'{14'd0,     ROW_PREDICT, '0},
			'{14'd16383, ROW_PREDICT, '0},
			'{14'd16383, ROW_PREDICT, '0},
			'{14'd1,     ROW_RESULT,  '{14'd16333, 8'd2, 8'd4, 24'd18, VERDICT_INTERVAL}},
			'{14'd0,     ROW_PREDICT, '0}
		};
	end

	initial begin
		mismatch_count = 0;
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		lim_min_interval = STEP_W'(RST_MIN_INTERVAL);
		lim_max_interval = STEP_W'(RST_MAX_INTERVAL);
		lim_min_range = PITCH_W'(RST_MIN_RANGE);
		lim_max_range = PITCH_W'(RST_MAX_RANGE);
		prev_pitch = '0;
		prev2_pitch = '0;
		next_frame = '0;
		seen_peak = 1'b0;
		anchor_frame = '0;
		anchor_pitch = '0;
		voiced_run = '0;
		trough_pitch = '0;
		steps_since_peak = '0;
		ramp_from = 6000;
		ramp_to = 6000;
		ramp_len = 1;
		ramp_pos = 1;
		ramp_base = 6000;
		ramp_up = 1'b0;
		drop_left = 0;
		long_pct = 2;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_MIN_INTERVAL;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, no idling
		for (int i = 0; i < 25; i++)
			feed_pitch(directed_plan[i].pitch, directed_plan[i].kind, directed_plan[i].want);
		run_random(200, -1, -1);
		settle();

		// widest limits, sender idles
		sender_idle_pct = 55;
		long_pct = 10;
		write_settings(1, 255, 0, 16383);
		run_random(220, -1, -1);
		settle();

		// random limits, receiver stalls, one long hold-off
		sender_idle_pct = 0;
		recv_stall_pct = 55;
		long_pct = 2;
		write_settings($urandom_range(1, 25), $urandom_range(15, 70), $urandom_range(0, 40),
			$urandom_range(200, 3000));
		run_random(220, -1, 60);
		settle();

		// tightest limits, height limits out of order, long ramps
		sender_idle_pct = 20;
		recv_stall_pct = 20;
		long_pct = 35;
		write_settings(255, 255, 16383, 0);
		run_random(220, -1, -1);
		settle();

		// zero minimum interval, sender drains once
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		long_pct = 2;
		write_settings(0, 60, $urandom_range(0, 40), $urandom_range(100, 2000));
		run_random(220, 100, -1);
		settle();

		// random limits, both sides idle
		sender_idle_pct = 20;
		recv_stall_pct = 20;
		write_settings($urandom_range(1, 25), $urandom_range(15, 70), $urandom_range(0, 40),
			$urandom_range(200, 3000));
		run_random(220, -1, -1);
		settle();

		// interval and height limits out of order
		sender_idle_pct = 55;
		recv_stall_pct = 0;
		write_settings(40, 10, 300, 50);
		run_random(220, -1, -1);
		settle();

		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== vibrato_peak_pair_qualifier_core.f =====
design/vppq_pkg.sv
design/vppq_cfg.sv
design/vppq_track.sv
design/vibrato_peak_pair_qualifier_core.sv
bench/vibrato_peak_pair_qualifier_core_test.sv
